// ===== rtl/core/drq_pkg.sv =====
// Shared types and constants for the deadline-ordered ready queue.
// Used by drq_store, drq_seq and the top level; depends on nothing else.
`default_nettype none

package drq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_REINSERT = 2'd2;

    localparam logic [7:0] BASE_PRIO_RST = 8'd31;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  task_id;
        logic [31:0] deadline;
    } t_req;

    typedef struct packed {
        logic [7:0] entry_task;
        logic [7:0] entry_priority;
        logic [5:0] entry_rank;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] dl;
    } t_slot;

    typedef struct packed {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        t_slot         wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/core/drq_store.sv =====
// Queue storage: one synchronous memory of id and deadline pairs, one read and one write port.
// Read data is registered, so it appears in the cycle after the address. Depends on drq_pkg.
`default_nettype none

module drq_store (
    input  logic              i_clk,
    input  drq_pkg::t_mem_req i_mreq,
    output drq_pkg::t_slot    o_rd_data
);
    import drq_pkg::*;

    t_slot r_mem [QUEUE_DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mreq.wr_en) begin
            r_mem[i_mreq.wr_addr] <= i_mreq.wr_data;
        end
        if (i_mreq.rd_en) begin
            r_rd_data <= r_mem[i_mreq.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/drq_seq.sv =====
// Request sequencer: remove pass, insertion shift pass and ranked read-out over drq_store.
// Holds the occupancy count and the registered result. Depends on drq_pkg.
`default_nettype none

module drq_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  drq_pkg::t_req     i_req,
    input  logic [7:0]        i_base_prio,
    output logic              o_busy,
    output drq_pkg::t_mem_req o_mreq,
    input  drq_pkg::t_slot    i_rd_data,
    output logic              o_strobe,
    output drq_pkg::t_res     o_res
);
    import drq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_PLACE,
        S_SHIFT,
        S_FRONT,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_ptr, n_ptr;
    logic          r_iss, n_iss;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pidx, n_pidx;
    logic          r_found, n_found;
    logic          r_strobe, n_strobe;
    t_req          r_req, n_req;
    t_res          r_res, n_res;

    t_mem_req      mreq;
    logic [CW-1:0] cnt_last;
    logic [CW-1:0] ptr_ext;
    logic [CW-1:0] pidx_ext;
    logic [7:0]    rank8;
    logic [7:0]    prio;
    t_slot         new_slot;

    assign cnt_last = r_cnt - CW'(1);
    assign ptr_ext  = CW'(r_ptr);
    assign pidx_ext = CW'(r_pidx);
    assign rank8    = 8'(r_pidx);
    assign prio     = (i_base_prio > rank8) ? (i_base_prio - rank8) : 8'd0;
    assign new_slot = '{id: r_req.task_id, dl: r_req.deadline};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_iss    = r_iss;
        n_found  = r_found;
        n_req    = r_req;
        n_res    = r_res;
        n_strobe = 1'b0;
        mreq         = '0;
        mreq.rd_addr = r_ptr;

        case (r_state)
            S_IDLE: begin
                n_ptr   = '0;
                n_iss   = 1'b1;
                n_found = 1'b0;
                if (i_start) begin
                    n_req = i_req;
                    case (i_req.mode)
                        MODE_INSERT:   n_state = S_PLACE;
                        MODE_REMOVE:   n_state = S_REMOVE;
                        MODE_REINSERT: n_state = S_REMOVE;
                        default:       n_state = S_EMIT;
                    endcase
                end
            end

            S_REMOVE: begin
                // Once the match is seen, every later entry moves down by one place.
                mreq.rd_en = r_iss;
                if (r_iss) begin
                    n_ptr = r_ptr + AW'(1);
                    if (ptr_ext == cnt_last) begin
                        n_iss = 1'b0;
                    end
                end
                if (r_pend) begin
                    if (r_found) begin
                        mreq.wr_en   = 1'b1;
                        mreq.wr_addr = r_pidx - AW'(1);
                        mreq.wr_data = i_rd_data;
                    end else if (i_rd_data.id == r_req.task_id) begin
                        n_found = 1'b1;
                    end
                end
                if ((r_cnt == '0) || (r_pend && (pidx_ext == cnt_last))) begin
                    if (n_found) begin
                        n_cnt = cnt_last;
                    end
                    n_state = (r_req.mode == MODE_REINSERT) ? S_PLACE : S_EMIT;
                    n_ptr   = '0;
                    n_iss   = 1'b1;
                end
            end

            S_PLACE: begin
                if (r_cnt == CW'(QUEUE_DEPTH)) begin
                    n_state = S_EMIT;
                    n_ptr   = '0;
                    n_iss   = 1'b1;
                end else if (r_cnt == '0) begin
                    n_state = S_FRONT;
                end else begin
                    n_state = S_SHIFT;
                    n_ptr   = AW'(cnt_last);
                    n_iss   = 1'b1;
                end
            end

            S_SHIFT: begin
                // Walk down from the tail, moving later deadlines up one place
                // until the new entry's slot is found.
                mreq.rd_en = r_iss;
                if (r_iss) begin
                    if (r_ptr == '0) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ptr = r_ptr - AW'(1);
                    end
                end
                if (r_pend) begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = r_pidx + AW'(1);
                    if (i_rd_data.dl > r_req.deadline) begin
                        mreq.wr_data = i_rd_data;
                        if (r_pidx == '0) begin
                            n_state = S_FRONT;
                            n_iss   = 1'b0;
                        end
                    end else begin
                        mreq.wr_data = new_slot;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_EMIT;
                        n_ptr   = '0;
                        n_iss   = 1'b1;
                    end
                end
            end

            S_FRONT: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = '0;
                mreq.wr_data = new_slot;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_EMIT;
                n_ptr   = '0;
                n_iss   = 1'b1;
            end

            S_EMIT: begin
                mreq.rd_en = r_iss && (r_cnt != '0);
                if (r_iss) begin
                    n_ptr = r_ptr + AW'(1);
                    if (ptr_ext == cnt_last) begin
                        n_iss = 1'b0;
                    end
                end
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end
                if (r_pend) begin
                    n_strobe             = 1'b1;
                    n_res.entry_task     = i_rd_data.id;
                    n_res.entry_priority = prio;
                    n_res.entry_rank     = 6'(r_pidx);
                    n_res.last           = (pidx_ext == cnt_last);
                    if (pidx_ext == cnt_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A read issued now returns next cycle; a change of state drops any read in flight.
        n_pend = mreq.rd_en && (n_state == r_state);
        n_pidx = r_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_iss    <= 1'b0;
            r_pend   <= 1'b0;
            r_pidx   <= '0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ptr    <= n_ptr;
            r_iss    <= n_iss;
            r_pend   <= n_pend;
            r_pidx   <= n_pidx;
            r_found  <= n_found;
            r_strobe <= n_strobe;
            r_req    <= n_req;
            r_res    <= n_res;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_mreq   = mreq;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/deadline_ordered_ready_queue.sv =====
// Top level of the deadline-ordered ready queue: configuration register, sequencer and storage.
// Depends on drq_pkg, drq_store and drq_seq.
//
//  Channel   Signals                          Transfer
//  request   start, busy, i_req               start high while busy low
//  result    o_strobe, o_res                  one cycle per strobe, cannot be held off
//  config    i_cfg_valid, o_cfg_ready,        valid and ready both high
//            i_cfg_data (base priority)
//
// A request runs, as its mode asks, a remove pass, a placement (a decision step, the shift
// from the tail and a final write at the front) and a read-out, all through the single memory
// read port; busy falls together with the strobe of the last result, or with no strobe if the
// queue is empty, and the next request may start then.
// The queue is empty after reset; the base priority resets to 31.
// Configuration writes are taken only while busy is low.
`default_nettype none

module deadline_ordered_ready_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  drq_pkg::t_req  i_req,
    output logic           o_strobe,
    output drq_pkg::t_res  o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);
    import drq_pkg::*;

    logic [7:0] r_base_prio;
    t_mem_req   mreq;
    t_slot      rd_data;
    logic       seq_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_prio <= BASE_PRIO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base_prio <= i_cfg_data;
        end
    end

    assign o_cfg_ready = !seq_busy;
    assign busy        = seq_busy;

    drq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_base_prio (r_base_prio),
        .o_busy      (seq_busy),
        .o_mreq      (mreq),
        .i_rd_data   (rd_data),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

    drq_store u_store (
        .i_clk     (i_clk),
        .i_mreq    (mreq),
        .o_rd_data (rd_data)
    );

`ifndef SYNTH
    a_strobe_in_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe outside a request");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |-> !busy)
        else $error("busy still high after the last result");
`endif

endmodule

`default_nettype wire

// ===== bench/drq_checker.sv =====
// Checker for the deadline-ordered ready queue: watches the request, result and
// configuration channels, keeps its own sorted copy of the queue and compares every entry.
// Depends on drq_pkg for the request and result types.
`timescale 1ns / 100ps

module drq_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  drq_pkg::t_req  i_req,
    input  logic           i_strobe,
    input  drq_pkg::t_res  i_res,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [7:0]     i_cfg_data,
    output int             o_mismatches,
    output int             o_pending,
    output int             o_requests,
    output int             o_entries
);
    import drq_pkg::*;

    localparam int REPORT_CAP = 20;

    logic [7:0]  sorted_ids [QUEUE_DEPTH];
    logic [31:0] sorted_dls [QUEUE_DEPTH];
    int          held_count = 0;
    logic [7:0]  base_prio  = BASE_PRIO_RST;
    t_res        ranking_q [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_requests   = 0;
        o_entries    = 0;
    end

    // Ties keep arrival order: the new task goes behind every equal deadline.
    function automatic void place_task(input logic [7:0] id, input logic [31:0] dl);
        int pos;
        int k;
        pos = 0;
        if (held_count >= QUEUE_DEPTH) return;
        while (pos < held_count && sorted_dls[pos] <= dl) pos++;
        for (k = held_count; k > pos; k--) begin
            sorted_ids[k] = sorted_ids[k - 1];
            sorted_dls[k] = sorted_dls[k - 1];
        end
        sorted_ids[pos] = id;
        sorted_dls[pos] = dl;
        held_count++;
    endfunction

    function automatic void pull_task(input logic [7:0] id);
        int pos;
        int k;
        pos = 0;
        while (pos < held_count && sorted_ids[pos] != id) pos++;
        if (pos >= held_count) return;
        for (k = pos; k + 1 < held_count; k++) begin
            sorted_ids[k] = sorted_ids[k + 1];
            sorted_dls[k] = sorted_dls[k + 1];
        end
        held_count--;
    endfunction

    function automatic void queue_ranking();
        t_res e;
        int   r;
        int   prio;
        for (r = 0; r < held_count; r++) begin
            prio             = int'(base_prio) - r;
            e.entry_task     = sorted_ids[r];
            e.entry_priority = (prio > 0) ? prio[7:0] : 8'd0;
            e.entry_rank     = r[5:0];
            e.last           = (r == held_count - 1);
            ranking_q.push_back(e);
        end
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (o_mismatches < REPORT_CAP)
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            held_count = 0;
            base_prio  = BASE_PRIO_RST;
            ranking_q.delete();
        end else begin
            if (i_strobe) begin
                o_entries++;
                if (ranking_q.size() == 0) begin
                    if (o_mismatches < REPORT_CAP)
                        $display("%0t: unexpected entry, expected none, got task %0h rank %0d",
                                 $time, i_res.entry_task, i_res.entry_rank);
                    o_mismatches++;
                end else begin
                    want = ranking_q.pop_front();
                    if (i_res.entry_task !== want.entry_task)
                        flag_field("entry_task", 32'(want.entry_task),
                                   32'(i_res.entry_task));
                    if (i_res.entry_priority !== want.entry_priority)
                        flag_field("entry_priority", 32'(want.entry_priority),
                                   32'(i_res.entry_priority));
                    if (i_res.entry_rank !== want.entry_rank)
                        flag_field("entry_rank", 32'(want.entry_rank),
                                   32'(i_res.entry_rank));
                    if (i_res.last !== want.last)
                        flag_field("last", 32'(want.last), 32'(i_res.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) base_prio = i_cfg_data;
            if (i_start && !i_busy) begin
                o_requests++;
                case (i_req.mode)
                    MODE_INSERT: place_task(i_req.task_id, i_req.deadline);
                    MODE_REMOVE: pull_task(i_req.task_id);
                    MODE_REINSERT: begin
                        pull_task(i_req.task_id);
                        place_task(i_req.task_id, i_req.deadline);
                    end
                    default: ;  // no update, the queue is still read out
                endcase
                queue_ranking();
            end
        end
        o_pending = ranking_q.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the deadline-ordered ready queue bench: clock, reset, request and configuration
// stimulus, watchdog and verdict. Depends on drq_pkg, the block and bench/drq_checker.sv.
`timescale 1ns / 100ps

module testbench;
    import drq_pkg::*;

    localparam logic [1:0] MODE_IDLE_PASS = 2'd3;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         PHASE_ITEMS    = 90;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    t_req       req;
    logic       res_strobe;
    t_res       res;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int mismatches;
    int pending;
    int requests_seen;
    int entries_seen;
    int cfg_writes;
    int stall_cycles;

    deadline_ordered_ready_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_strobe    (res_strobe),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    drq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_strobe     (res_strobe),
        .i_res        (res),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_requests   (requests_seen),
        .o_entries    (entries_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Any request, result or register write counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_strobe || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("deadline_ordered_ready_queue: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int random_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(4, 1);
        return $urandom_range(40, 12);
    endfunction

    function automatic t_req random_request(input int id_span, input int insert_pct);
        t_req r;
        int   p;
        p = $urandom_range(99);
        if (p < insert_pct)  r.mode = MODE_INSERT;
        else if (p < 70)     r.mode = MODE_REMOVE;
        else if (p < 90)     r.mode = MODE_REINSERT;
        else                 r.mode = MODE_IDLE_PASS;
        // A narrow id pool makes removes hit and duplicates appear; now and then any id.
        if ($urandom_range(9) == 0) r.task_id = 8'($urandom);
        else                        r.task_id = 8'($urandom_range(id_span - 1));
        p = $urandom_range(99);
        if (p < 40)      r.deadline = $urandom_range(15);
        else if (p < 85) r.deadline = $urandom;
        else if (p < 93) r.deadline = 32'h0000_0000;
        else             r.deadline = 32'hFFFF_FFFF;
        return r;
    endfunction

    // Holds start high until the request is taken; start stays high afterwards so that a
    // following request with no gap goes straight on.
    task automatic issue_request(input t_req r, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic send(input logic [1:0] mode, input logic [7:0] id, input logic [31:0] dl);
        t_req r;
        r.mode     = mode;
        r.task_id  = id;
        r.deadline = dl;
        issue_request(r, random_gap());
    endtask

    // A request on an empty queue gives no entries, so allow the block time to finish it.
    task automatic wait_until_idle();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base_priority(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_phase(input int id_span, input int insert_pct, input bit gaps_on);
        t_req r;
        repeat (PHASE_ITEMS) begin
            r = random_request(id_span, insert_pct);
            issue_request(r, gaps_on ? random_gap() : 0);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        cfg_writes   = 0;
        stall_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, base priority at its reset value.
        send(MODE_REMOVE,    8'h05, 32'h0000_0000);   // empty queue
        send(MODE_IDLE_PASS, 8'h00, 32'h0000_0000);   // empty queue, no update
        send(MODE_REINSERT,  8'h10, 32'd500);         // reinsert without a match inserts
        send(MODE_INSERT,    8'h00, 32'h0000_0000);
        send(MODE_INSERT,    8'hFF, 32'hFFFF_FFFF);
        send(MODE_INSERT,    8'h21, 32'd500);         // equal deadline goes behind
        send(MODE_INSERT,    8'h21, 32'd40);          // duplicate id
        send(MODE_REMOVE,    8'h21, 32'h0000_0000);   // only the first match goes
        send(MODE_REMOVE,    8'h77, 32'h0000_0000);   // no match
        send(MODE_REINSERT,  8'h10, 32'h8000_0000);
        send(MODE_INSERT,    8'hAA, 32'hAAAA_AAAA);
        send(MODE_INSERT,    8'h55, 32'h5555_5555);
        send(MODE_INSERT,    8'h3C, 32'd500);
        send(MODE_INSERT,    8'hC3, 32'hFFFF_FFFF);   // queue now full
        send(MODE_INSERT,    8'h99, 32'd1);           // dropped
        send(MODE_REINSERT,  8'h98, 32'd2);           // no match and full, dropped
        send(MODE_REINSERT,  8'hFF, 32'h0000_0000);   // full but matched, moves up behind task 00's equal deadline
        send(MODE_IDLE_PASS, 8'hFF, 32'hFFFF_FFFF);

        wait_until_idle();
        write_base_priority(8'd0);
        run_phase(8, 35, 1'b1);

        wait_until_idle();
        write_base_priority(8'd255);
        run_phase(8, 50, 1'b0);

        wait_until_idle();
        write_base_priority(8'd3);
        run_phase(12, 35, 1'b1);

        wait_until_idle();
        write_base_priority(8'($urandom));
        run_phase(6, 20, 1'b1);

        wait_until_idle();
        write_base_priority(8'd1);
        run_phase(16, 45, 1'b1);

        wait_until_idle();
        @(negedge clk);
        $display("Covered %0d requests and %0d ranked entries over %0d base priority settings,",
                 requests_seen, entries_seen, cfg_writes + 1);
        $display("with empty and full queues, ties, duplicates and dropped inserts.");
        if (mismatches == 0 && pending == 0) begin
            $display("deadline_ordered_ready_queue: match");
        end else begin
            $display("deadline_ordered_ready_queue: mismatch");
        end
        $finish;
    end

endmodule
